// ===== hdl/ole_pkg.sv =====
// Package for the ordered list engine: command and status codes, shared types.
// No dependencies.
`default_nettype none
package ole_pkg;

   typedef enum logic [3:0] {
      CMD_PUSH_FRONT = 4'd0,
      CMD_PUSH_BACK  = 4'd1,
      CMD_INS_AFTER  = 4'd2,
      CMD_POP_FRONT  = 4'd3,
      CMD_POP_BACK   = 4'd4,
      CMD_DEL_MATCH  = 4'd5,
      CMD_SEARCH     = 4'd6,
      CMD_DEL_ALL    = 4'd7,
      CMD_MIDDLE     = 4'd8,
      CMD_REVERSE    = 4'd9
   } cmd_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam int DATA_W = 32;

   // Per-cycle operation broadcast from the sequencer to every cell
   typedef enum logic [2:0] {
      OP_HOLD    = 3'd0,
      OP_SHR     = 3'd1, // take left neighbour for index > pos, load value at pos
      OP_SHL     = 3'd2, // take right neighbour for index >= pos
      OP_ROTL    = 3'd3, // whole row rotates left, last takes head
      OP_REVSTEP = 3'd4  // reverse prefix: cell i takes cell i+1 for i < pos, pos takes head
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [10:0] pos;
      logic [31:0] data;
   } cell_ctrl_type;

endpackage
`default_nettype wire

// ===== hdl/ole_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface ole_if #(parameter int W = 8) (input wire logic clock);
   logic         valid;
   logic         ready;
   logic [W-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/ole_cell.sv =====
// One list cell: holds one entry, shifts with its neighbours on command.
// Depends on ole_pkg.
`default_nettype none
module ole_cell
   import ole_pkg::*;
#(
   parameter int IDX_W = 6,
   parameter int INDEX = 0
) (
   input  wire logic              clock,
   input  wire cell_ctrl_type     ctrl,
   input  wire logic [DATA_W-1:0] left_data,
   input  wire logic [DATA_W-1:0] right_data,
   input  wire logic [DATA_W-1:0] head_data,
   input  wire logic              is_last,
   output logic [DATA_W-1:0]      data_ff
);
   logic [DATA_W-1:0] data_in;
   logic [IDX_W:0]    my_idx;
   logic [IDX_W:0]    pos;

   assign my_idx = (IDX_W+1)'(INDEX);
   assign pos    = ctrl.pos[IDX_W:0];

   // choose next content from the broadcast operation
   always_comb begin
      data_in = data_ff;
      unique case (ctrl.op)
         OP_SHR: begin
            if (my_idx > pos) data_in = left_data;
            else if (my_idx == pos) data_in = ctrl.data;
         end
         OP_SHL:  if (my_idx >= pos) data_in = right_data;
         OP_ROTL: data_in = is_last ? head_data : right_data;
         OP_REVSTEP: begin
            if (my_idx < pos) data_in = right_data;
            else if (my_idx == pos) data_in = head_data;
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end
endmodule
`default_nettype wire

// ===== hdl/ole_ctrl.sv =====
// Sequencer: decodes a command, scans the cell row via rotation, steers shifts.
// Depends on ole_pkg.
`default_nettype none
module ole_ctrl
   import ole_pkg::*;
#(
   parameter int CAPACITY = 64,
   parameter int IDX_W    = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  wire logic [3:0]        cmd,
   input  wire logic [DATA_W-1:0] value,
   input  wire logic [DATA_W-1:0] ref_value,
   input  wire logic [DATA_W-1:0] head_data,
   input  wire logic [DATA_W-1:0] mid_data,
   output cell_ctrl_type          ctrl,
   output logic [IDX_W:0]         list_len,
   output logic [IDX_W:0]         last_idx,
   output logic                   res_valid,
   input  wire logic              res_ready,
   output logic [1:0]             res_status,
   output logic [5:0]             res_position,
   output logic [31:0]            res_middle,
   output logic [6:0]             res_removed,
   output logic [6:0]             res_length
);
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SCAN = 5'b00010, // rotate whole list once, head shows each entry
      S_EDIT = 5'b00100, // single shift
      S_REV  = 5'b01000, // reverse steps
      S_OUT  = 5'b10000
   } state_type;

   state_type      state_ff, state_in;
   logic [3:0]     cmd_ff, cmd_in;
   logic [31:0]    val_ff, val_in, key_ff, key_in;
   logic [IDX_W:0] len_ff, len_in;
   logic [IDX_W:0] cnt_ff, cnt_in;   // scan index
   logic [IDX_W:0] kept_ff, kept_in; // kept entries in delete-all
   logic [IDX_W:0] hit_ff, hit_in;   // first match index
   logic           found_ff, found_in;
   logic [IDX_W:0] epos_ff, epos_in;
   logic [1:0]     st_ff, st_in;
   logic [31:0]    mid_ff, mid_in;
   logic [IDX_W:0] rem_ff, rem_in;
   logic [5:0]     posn_ff, posn_in;
   logic           match;

   assign cmd_ready  = state_ff == S_IDLE;
   assign res_valid  = state_ff == S_OUT;
   assign res_status = st_ff;
   assign res_position = posn_ff;
   assign res_middle = mid_ff;
   assign res_removed = 7'(rem_ff);
   assign res_length = 7'(len_ff);
   assign match = head_data == key_ff;
   assign list_len = len_ff;
   // last live cell of the rotation; dropped entries shorten the row
   assign last_idx = len_ff - rem_ff - 1'b1;

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; val_in = val_ff; key_in = key_ff;
      len_in = len_ff; cnt_in = cnt_ff; kept_in = kept_ff; hit_in = hit_ff;
      found_in = found_ff; epos_in = epos_ff; st_in = st_ff; mid_in = mid_ff;
      rem_in = rem_ff; posn_in = posn_ff;
      ctrl = '{op: OP_HOLD, pos: '0, data: val_ff};
      unique case (state_ff)
         S_IDLE: if (cmd_valid) begin
            cmd_in = cmd; val_in = value; key_in = ref_value;
            st_in = ST_OK; mid_in = '0; rem_in = '0; posn_in = '0;
            cnt_in = '0; kept_in = '0; found_in = 1'b0; hit_in = '0;
            state_in = S_OUT;
            unique case (cmd)
               CMD_PUSH_FRONT, CMD_PUSH_BACK:
                  if (len_ff == (IDX_W+1)'(CAPACITY)) st_in = ST_FULL;
                  else begin
                     epos_in = (cmd == CMD_PUSH_FRONT) ? '0 : len_ff;
                     state_in = S_EDIT;
                  end
               CMD_INS_AFTER:
                  if (len_ff == 0) st_in = ST_EMPTY;
                  else if (len_ff == (IDX_W+1)'(CAPACITY)) st_in = ST_FULL;
                  else state_in = S_SCAN;
               CMD_POP_FRONT, CMD_POP_BACK:
                  if (len_ff == 0) st_in = ST_EMPTY;
                  else begin
                     epos_in = (cmd == CMD_POP_FRONT) ? '0 : len_ff - 1'b1;
                     state_in = S_EDIT;
                  end
               CMD_DEL_MATCH, CMD_DEL_ALL, CMD_REVERSE:
                  if (len_ff == 0) st_in = ST_EMPTY;
                  else begin
                     state_in = (cmd == CMD_REVERSE) ? S_REV : S_SCAN;
                     cnt_in = (cmd == CMD_REVERSE) ? len_ff - 1'b1 : '0;
                  end
               CMD_SEARCH:
                  if (len_ff == 0) st_in = ST_NOTFOUND;
                  else state_in = S_SCAN;
               CMD_MIDDLE:
                  if (len_ff == 0) st_in = ST_EMPTY;
                  else mid_in = mid_data;
               default: ;
            endcase
         end
         S_SCAN: begin
            // rotate; head shows entry cnt. Delete-all drops matches as they pass.
            if (cmd_ff == CMD_DEL_ALL && match) begin
               ctrl.op  = OP_SHL;
               ctrl.pos = '0;
               rem_in   = rem_ff + 1'b1;
            end else begin
               ctrl.op  = OP_ROTL;
               ctrl.pos = '0;
               kept_in  = kept_ff + 1'b1;
            end
            if (match && !found_ff) begin
               found_in = 1'b1;
               hit_in   = cnt_ff;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == len_ff - 1'b1) begin
               state_in = S_OUT;
               if (cmd_ff == CMD_DEL_ALL) begin
                  len_in = (cmd_ff == CMD_DEL_ALL && match) ? kept_ff : kept_ff + 1'b1;
               end else if (!(found_ff || match)) begin
                  st_in = ST_NOTFOUND;
               end else begin
                  epos_in = found_ff ? hit_ff : cnt_ff;
                  if (cmd_ff == CMD_SEARCH) posn_in = 6'(found_ff ? hit_ff : cnt_ff);
                  else if (cmd_ff == CMD_INS_AFTER) begin
                     epos_in = (found_ff ? hit_ff : cnt_ff) + 1'b1;
                     state_in = S_EDIT;
                  end else state_in = S_EDIT;
               end
            end
         end
         S_EDIT: begin
            ctrl.pos = 11'(epos_ff);
            if (cmd_ff == CMD_POP_FRONT || cmd_ff == CMD_POP_BACK ||
                cmd_ff == CMD_DEL_MATCH) begin
               ctrl.op = OP_SHL;
               len_in  = len_ff - 1'b1;
            end else begin
               ctrl.op = OP_SHR;
               len_in  = len_ff + 1'b1;
            end
            state_in = S_OUT;
         end
         S_REV: begin
            // move head to position cnt, shifting the prefix left
            ctrl.op  = OP_REVSTEP;
            ctrl.pos = 11'(cnt_ff);
            if (cnt_ff <= 1) state_in = S_OUT;
            cnt_in = cnt_ff - 1'b1;
         end
         S_OUT: if (res_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
      end
      cmd_ff <= cmd_in; val_ff <= val_in; key_ff <= key_in; cnt_ff <= cnt_in;
      kept_ff <= kept_in; hit_ff <= hit_in; found_ff <= found_in;
      epos_ff <= epos_in; st_ff <= st_in; mid_ff <= mid_in; rem_ff <= rem_in;
      posn_ff <= posn_in;
   end
endmodule
`default_nettype wire

// ===== hdl/ordered_list_engine.sv =====
// Ordered list engine: a row of CAPACITY cells plus a sequencer.
// Middle, refused and unused commands go straight to the result; push/pop take one
// shift; search and delete-all scan the row, delete-match and insert-after scan then
// shift, reverse runs its reverse steps; scans rotate the row once past the head.
// One command at a time; the next beat is taken in the cycle after the result beat.
// Synchronous reset empties the list; cell contents are not cleared.
`default_nettype none
module ordered_list_engine
   import ole_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input wire logic clock,
   input wire logic reset,
   ole_if.sink      req,
   ole_if.source    rsp
);
   localparam int IDX_W = $clog2(CAPACITY);

   cell_ctrl_type     ctrl;
   logic [DATA_W-1:0] cells [CAPACITY];
   logic [DATA_W-1:0] mid_data;
   logic [IDX_W:0]    list_len;
   logic [IDX_W:0]    last_idx;
   logic [1:0]        status;
   logic [5:0]        position;
   logic [31:0]       middle;
   logic [6:0]        removed, length_now;

   // middle entry read at length/2
   assign mid_data = cells[list_len[IDX_W:1]];

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      ole_cell #(.IDX_W(IDX_W), .INDEX(g)) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .left_data (cells[(g + CAPACITY - 1) % CAPACITY]),
         .right_data(cells[(g + 1) % CAPACITY]),
         .head_data (cells[0]),
         .is_last   ((IDX_W+1)'(g) == last_idx),
         .data_ff   (cells[g])
      );
   end

   ole_ctrl #(.CAPACITY(CAPACITY), .IDX_W(IDX_W)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (req.valid),
      .cmd_ready   (req.ready),
      .cmd         (req.payload[67:64]),
      .value       (req.payload[63:32]),
      .ref_value   (req.payload[31:0]),
      .head_data   (cells[0]),
      .mid_data    (mid_data),
      .ctrl        (ctrl),
      .list_len    (list_len),
      .last_idx    (last_idx),
      .res_valid   (rsp.valid),
      .res_ready   (rsp.ready),
      .res_status  (status),
      .res_position(position),
      .res_middle  (middle),
      .res_removed (removed),
      .res_length  (length_now)
   );

   assign rsp.payload = {status, position, middle, removed, length_now};
endmodule
`default_nettype wire

// ===== hdl/ole_checker.sv =====
// Port-level checker for the ordered list engine, bound to the top level.
// Depends on the top level port names.
`default_nettype none
module ole_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [53:0] rsp_payload
);
   // one command in flight: no new beat while a result waits
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result pending");
   // result holds while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped");
   // length never exceeds 64
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload[6:0] <= 7'd64) else $error("length out of range");
endmodule

bind ordered_list_engine ole_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload));
`default_nettype wire
